// File: rtl/isqrtn_pkg.sv
// ============================================================================
// isqrtn_pkg
// Shared widths, microcode types and step addresses for the Newton-Raphson
// integer square root.
// ============================================================================
package isqrtn_pkg;

    // Operand and result widths.
    localparam int VAL_W  = 32;
    localparam int ROOT_W = 16;

    // Every estimate stays below 2^17 (the largest seed is 2^16), so 17
    // bits hold it. The quotient of a Newton step stays below 2^17; it is
    // built two bits per cycle, so it is kept as an 18-bit word.
    localparam int EST_W      = 17;
    localparam int QUO_W      = 18;
    localparam int DIV_STEPS  = QUO_W / 2;
    localparam int CNT_W      = $clog2(DIV_STEPS);
    localparam int MSB_W      = $clog2(VAL_W);

    // Control store geometry.
    localparam int UPC_DEPTH = 11;
    localparam int UPC_W     = $clog2(UPC_DEPTH);

    typedef logic [UPC_W-1:0] t_pc;
    typedef logic [EST_W-1:0] t_est;
    typedef logic [QUO_W-1:0] t_quo;
    typedef logic [CNT_W-1:0] t_cnt;

    // Datapath operations.
    typedef enum logic [2:0] {
        OP_WAIT,      // ready for an operand; capture it on a beat
        OP_SEED,      // form the starting estimate, prime the divider
        OP_DSTEP,     // two quotient bits
        OP_UPD_INIT,  // take the new estimate, prime the divider
        OP_CHK_INIT,  // take the new estimate unless converged, prime divider
        OP_CHK,       // take the new estimate unless converged
        OP_EMIT       // hand the estimate to the output register
    } t_op;

    // Jump conditions. When the condition holds the sequencer goes to the
    // target of the control word, otherwise to the next word.
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_NO_BEAT,
        COND_TRIVIAL,
        COND_DIV_MORE,
        COND_CONVERGED,
        COND_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        t_op  op;
        logic load;
    } t_dp_ctl;

    // Status from the datapath back to the sequencer.
    typedef struct packed {
        logic trivial;
        logic div_more;
        logic converged;
    } t_dp_stat;

    // Step addresses of the program.
    localparam t_pc UPC_WAIT  = t_pc'(0);
    localparam t_pc UPC_SEED  = t_pc'(1);
    localparam t_pc UPC_DIV1  = t_pc'(2);
    localparam t_pc UPC_UPD1  = t_pc'(3);
    localparam t_pc UPC_DIV2  = t_pc'(4);
    localparam t_pc UPC_CHK2  = t_pc'(5);
    localparam t_pc UPC_DIV3  = t_pc'(6);
    localparam t_pc UPC_CHK3  = t_pc'(7);
    localparam t_pc UPC_DIV4  = t_pc'(8);
    localparam t_pc UPC_CHK4  = t_pc'(9);
    localparam t_pc UPC_EMIT  = t_pc'(10);
    localparam t_pc UPC_LAST  = t_pc'(UPC_DEPTH - 1);

endpackage

// File: rtl/isqrtn_urom.sv
// ============================================================================
// isqrtn_urom
// Read-only control store holding the square root program.
// ============================================================================
module isqrtn_urom (
    input  isqrtn_pkg::t_pc    i_pc,
    output isqrtn_pkg::t_uword o_uword
);
    import isqrtn_pkg::*;

    // Divider words loop on themselves until the step count runs out; the
    // wait and emit words loop on themselves while their channel stalls.
    always_comb begin
        case (i_pc)
            UPC_WAIT: o_uword = '{op: OP_WAIT,     cond: COND_NO_BEAT,   target: UPC_WAIT};
            UPC_SEED: o_uword = '{op: OP_SEED,     cond: COND_TRIVIAL,   target: UPC_EMIT};
            UPC_DIV1: o_uword = '{op: OP_DSTEP,    cond: COND_DIV_MORE,  target: UPC_DIV1};
            UPC_UPD1: o_uword = '{op: OP_UPD_INIT, cond: COND_NEVER,     target: UPC_WAIT};
            UPC_DIV2: o_uword = '{op: OP_DSTEP,    cond: COND_DIV_MORE,  target: UPC_DIV2};
            UPC_CHK2: o_uword = '{op: OP_CHK_INIT, cond: COND_CONVERGED, target: UPC_EMIT};
            UPC_DIV3: o_uword = '{op: OP_DSTEP,    cond: COND_DIV_MORE,  target: UPC_DIV3};
            UPC_CHK3: o_uword = '{op: OP_CHK_INIT, cond: COND_CONVERGED, target: UPC_EMIT};
            UPC_DIV4: o_uword = '{op: OP_DSTEP,    cond: COND_DIV_MORE,  target: UPC_DIV4};
            UPC_CHK4: o_uword = '{op: OP_CHK,      cond: COND_NEVER,     target: UPC_WAIT};
            UPC_EMIT: o_uword = '{op: OP_EMIT,     cond: COND_OUT_BUSY,  target: UPC_EMIT};
            default:  o_uword = '{op: OP_WAIT,     cond: COND_NEVER,     target: UPC_WAIT};
        endcase
    end

endmodule

// File: rtl/isqrtn_dp.sv
// ============================================================================
// isqrtn_dp
// Datapath: operand register, seed logic, radix-4 restoring divider and the
// Newton update with its convergence compare.
// ============================================================================
module isqrtn_dp (
    input  logic                                 i_clk,
    input  isqrtn_pkg::t_dp_ctl                  i_ctl,
    input  logic [isqrtn_pkg::VAL_W-1:0]         i_value,
    output isqrtn_pkg::t_dp_stat                 o_stat,
    output logic [isqrtn_pkg::ROOT_W-1:0]        o_est
);
    import isqrtn_pkg::*;

    logic [VAL_W-1:0]  r_s;
    t_est              r_x,   n_x;
    t_est              r_rem, n_rem;
    t_quo              r_dvd, n_dvd;
    t_quo              r_q,   n_q;
    t_cnt              r_cnt, n_cnt;

    logic [MSB_W-1:0]  msb;
    logic [MSB_W-1:0]  b;
    t_est              x_seed;
    logic [EST_W:0]    t1, t2, xz;
    logic              ge1, ge2;
    t_est              r1;
    logic [EST_W:0]    sum;
    t_est              x_new;
    logic              trivial;
    logic              converged;

    assign trivial = (r_s[VAL_W-1:1] == '0);

    // Starting estimate: with b one below the leading one position, the seed
    // is 2 or 3 (by the low bit of b) shifted left by half of b.
    always_comb begin
        msb = '0;
        for (int i = 0; i < VAL_W; i++) begin
            if (r_s[i]) begin
                msb = MSB_W'(i);
            end
        end
        b      = msb - MSB_W'(1);
        x_seed = t_est'({1'b1, b[0]}) << b[MSB_W-1:1];
    end

    // Two restoring division steps per cycle.
    always_comb begin
        xz  = {1'b0, r_x};
        t1  = {r_rem, r_dvd[QUO_W-1]};
        ge1 = (t1 >= xz);
        r1  = ge1 ? t_est'(t1 - xz) : t_est'(t1);
        t2  = {r1, r_dvd[QUO_W-2]};
        ge2 = (t2 >= xz);
    end

    // Newton update: the average of the estimate and the quotient.
    assign sum       = {1'b0, r_x} + {1'b0, r_q[EST_W-1:0]};
    assign x_new     = sum[EST_W:1];
    assign converged = (x_new >= r_x);

    always_comb begin
        n_x   = r_x;
        n_rem = r_rem;
        n_dvd = r_dvd;
        n_q   = r_q;
        n_cnt = r_cnt;
        case (i_ctl.op)
            OP_SEED: begin
                n_x = trivial ? t_est'(r_s[0]) : x_seed;
            end
            OP_DSTEP: begin
                n_rem = ge2 ? t_est'(t2 - xz) : t_est'(t2);
                n_dvd = {r_dvd[QUO_W-3:0], 2'b00};
                n_q   = {r_q[QUO_W-3:0], ge1, ge2};
                n_cnt = r_cnt - t_cnt'(1);
            end
            OP_UPD_INIT: begin
                n_x = x_new;
            end
            OP_CHK_INIT, OP_CHK: begin
                if (!converged) begin
                    n_x = x_new;
                end
            end
            default: begin
            end
        endcase
        // Prime the divider: the top dividend bits are always below the
        // divisor, so they seed the partial remainder directly.
        if (i_ctl.op == OP_SEED || i_ctl.op == OP_UPD_INIT || i_ctl.op == OP_CHK_INIT) begin
            n_rem = t_est'(r_s[VAL_W-1:QUO_W]);
            n_dvd = r_s[QUO_W-1:0];
            n_cnt = t_cnt'(DIV_STEPS - 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_s <= i_value;
        end
        r_x   <= n_x;
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_q   <= n_q;
        r_cnt <= n_cnt;
    end

    assign o_stat = '{trivial: trivial, div_more: (r_cnt != '0), converged: converged};
    assign o_est  = r_x[ROOT_W-1:0];

endmodule

// File: rtl/integer_square_root_newton.sv
// ============================================================================
// integer_square_root_newton
// Floor square root of a 32-bit unsigned operand by Newton-Raphson steps.
// ============================================================================
// Usage: an operand beat arrives on i_valid / o_ready / i_value and one result
// beat leaves on o_valid / i_ready / o_root for each operand. The block works
// on one operand at a time; o_ready is high only while the program sits on its
// wait step, and the result sits in an output register so that the next
// operand can be taken while the result still waits for the receiver.
// Operands 0 and 1 go from the seed step straight to the emit step. Others
// take the seed through up to four Newton steps; the result is emitted as
// soon as the estimate no longer falls after the second or third step, or
// else after the fourth. Each Newton step runs a divider that retires two
// quotient bits per cycle, then takes the new estimate. The block takes the
// next operand only once the emit step has passed and it is back on wait.
// Reset (synchronous, active low) returns the program to its wait step and
// drops o_valid. If the receiver stalls with a result still held, a finished
// result waits on the emit step until the output register frees up.
// ============================================================================
module integer_square_root_newton (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [isqrtn_pkg::VAL_W-1:0]          i_value,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [isqrtn_pkg::ROOT_W-1:0]         o_root
);
    import isqrtn_pkg::*;

    t_pc      r_pc, n_pc;
    t_uword   uword;
    t_dp_ctl  dp_ctl;
    t_dp_stat dp_stat;
    logic [ROOT_W-1:0] est;
    logic [ROOT_W-1:0] r_root;
    logic     r_out_valid, n_out_valid;
    logic     in_beat;
    logic     out_busy;
    logic     cond_true;
    logic     emit_load;

    // Control store lookup for the current step.
    isqrtn_urom u_urom (
        .i_pc    (r_pc),
        .o_uword (uword)
    );

    assign o_ready   = (uword.op == OP_WAIT);
    assign in_beat   = i_valid && o_ready;
    assign out_busy  = r_out_valid && !i_ready;
    assign emit_load = (uword.op == OP_EMIT) && !out_busy;

    assign dp_ctl = '{op: uword.op, load: in_beat};

    isqrtn_dp u_dp (
        .i_clk   (i_clk),
        .i_ctl   (dp_ctl),
        .i_value (i_value),
        .o_stat  (dp_stat),
        .o_est   (est)
    );

    // Jump condition selected by the control word.
    always_comb begin
        case (uword.cond)
            COND_NEVER:     cond_true = 1'b0;
            COND_NO_BEAT:   cond_true = !in_beat;
            COND_TRIVIAL:   cond_true = dp_stat.trivial;
            COND_DIV_MORE:  cond_true = dp_stat.div_more;
            COND_CONVERGED: cond_true = dp_stat.converged;
            COND_OUT_BUSY:  cond_true = out_busy;
            default:        cond_true = 1'b0;
        endcase
    end

    // Step counter: jump, or advance and wrap from the last step to the start.
    always_comb begin
        if (cond_true) begin
            n_pc = uword.target;
        end else if (r_pc == UPC_LAST) begin
            n_pc = UPC_WAIT;
        end else begin
            n_pc = r_pc + t_pc'(1);
        end
    end

    // Output register: loaded on the emit step, cleared when the beat leaves.
    always_comb begin
        n_out_valid = r_out_valid;
        if (emit_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= UPC_WAIT;
            r_out_valid <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            r_root <= est;
        end
    end

    assign o_valid = r_out_valid;
    assign o_root  = r_root;

`ifndef SYNTHESIS
    // An accepted operand always starts the seed step next.
    a_beat_to_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> (r_pc == UPC_SEED))
        else $error("operand beat not followed by the seed step");

    // A result leaving the emit step shows up on the output next cycle.
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_load |=> (o_valid && (r_pc == UPC_WAIT)))
        else $error("emitted result not presented");

    // The step counter never leaves the program.
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= UPC_LAST)
        else $error("step counter outside the program");

    // The divider never runs out of steps while still looping.
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((uword.op == OP_DSTEP) && !dp_stat.div_more) |=> (uword.op != OP_DSTEP))
        else $error("divider step count out of step with the program");
`endif

endmodule

// File: tb/isqrtn_root_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// isqrtn_root_checker
// Watches the operand and result channels of the square root block, predicts
// the floor square root of every accepted operand and compares each result
// beat against the oldest prediction still waiting.
// ============================================================================
module isqrtn_root_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_value_valid,
    input  logic                          i_value_ready,
    input  logic [isqrtn_pkg::VAL_W-1:0]  i_value,
    input  logic                          i_root_valid,
    input  logic                          i_root_ready,
    input  logic [isqrtn_pkg::ROOT_W-1:0] i_root,
    output int unsigned                   o_fail_count,
    output int unsigned                   o_pending
);
    import isqrtn_pkg::*;

    typedef struct packed {
        logic [VAL_W-1:0]  operand;
        logic [ROOT_W-1:0] root;
    } t_root_job;

    t_root_job   expected_roots[$];
    t_root_job   oldest_job;
    int unsigned fail_tally = 0;

    // One Newton step with integer division; the sum is formed one bit wider.
    function automatic logic [31:0] newton_refine(input logic [31:0] operand,
                                                  input logic [31:0] guess);
        logic [31:0] quotient;
        logic [32:0] total;
        quotient = (guess == 32'd0) ? 32'hFFFF_FFFF : operand / guess;
        total    = {1'b0, guess} + {1'b0, quotient};
        return total[32:1];
    endfunction

    // The seed is a power of two times 2 or 3, picked from the position of
    // the leading one. Up to four steps follow; from the second on, the loop
    // stops as soon as the estimate no longer falls.
    function automatic logic [ROOT_W-1:0] predict_root(input logic [VAL_W-1:0] operand);
        int unsigned lead;
        logic [31:0] span;
        logic [31:0] prev;
        logic [31:0] next;
        if (operand <= 32'd1) return operand[ROOT_W-1:0];
        lead = 0;
        while (lead < VAL_W && operand[VAL_W-1-lead] == 1'b0) lead++;
        span = 32'd30 - lead;
        prev = (32'd1 << (span >> 1)) * (32'd2 + (span & 32'd1));
        next = newton_refine(operand, prev);
        prev = newton_refine(operand, next);
        if (prev >= next) return next[ROOT_W-1:0];
        next = newton_refine(operand, prev);
        if (next >= prev) return prev[ROOT_W-1:0];
        prev = newton_refine(operand, next);
        if (prev >= next) return next[ROOT_W-1:0];
        return prev[ROOT_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_roots.delete();
        end else begin
            if (i_root_valid && i_root_ready) begin
                if (expected_roots.size() == 0) begin
                    $display("%0t: unexpected root beat: expected none, actual %0d",
                             $time, i_root);
                    fail_tally++;
                end else begin
                    oldest_job = expected_roots.pop_front();
                    if (i_root !== oldest_job.root) begin
                        $display("%0t: root of %h: expected %0d, actual %0d",
                                 $time, oldest_job.operand, oldest_job.root, i_root);
                        fail_tally++;
                    end
                end
            end
            if (i_value_valid && i_value_ready) begin
                expected_roots.push_back('{operand: i_value, root: predict_root(i_value)});
            end
        end
        o_fail_count <= fail_tally;
        o_pending    <= expected_roots.size();
    end

endmodule

// File: tb/tb_integer_square_root_newton.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_integer_square_root_newton
// Operand stimulus, result back-pressure and final verdict for the Newton-
// Raphson integer square root. A directed set of boundary operands is
// followed by random operands; a separate checker predicts every root.
// ============================================================================
module tb_integer_square_root_newton;
    import isqrtn_pkg::*;

    // The random part is about 1800 operands. A normal run stays far below
    // the cycle limit, which also covers the worst sender gaps and receiver
    // stalls on every beat.
    localparam int unsigned RANDOM_ITEMS  = 1800;
    localparam int unsigned DRAIN_CYCLES  = 100;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned CYCLE_LIMIT   = 1_500_000;
    localparam int          DIRECTED_CNT  = 22;

    // Boundary operands: the pass-through values zero and one, the smallest
    // seeded values, every shape of the leading one at the top of the range,
    // perfect squares and their neighbors, and alternating bit patterns.
    localparam logic [VAL_W-1:0] DIRECTED_OPS [DIRECTED_CNT] = '{
        32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
        32'h0000_0004, 32'h0000_0008, 32'h0000_000F, 32'h0000_0010,
        32'h0000_0018, 32'h0000_0019, 32'h3FFF_FFFF, 32'h4000_0000,
        32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFE_0000, 32'hFFFE_0001,
        32'hFFFE_0000 + 32'h0000_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
        32'hAAAA_AAAA, 32'h5555_5555, 32'h0001_0000
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [VAL_W-1:0]  i_value;
    logic              o_valid;
    logic              i_ready;
    logic [ROOT_W-1:0] o_root;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned cycle_count = 0;

    integer_square_root_newton u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_value (i_value),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_root  (o_root)
    );

    isqrtn_root_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_value_valid (i_valid),
        .i_value_ready (o_ready),
        .i_value       (i_value),
        .i_root_valid  (o_valid),
        .i_root_ready  (i_ready),
        .i_root        (o_root),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The watchdog ends a hung run; nothing else in this process follows it.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Random operands favor the interesting corners: short operands where the
    // seed is crude, values right next to a perfect square where the floor is
    // easiest to get wrong, and the very top of the range. Four in ten or so
    // are plain uniform words, which toggle every bit of the operand both ways.
    function automatic logic [VAL_W-1:0] random_operand();
        logic [VAL_W-1:0] base;
        int unsigned      pick;
        pick = $urandom_range(0, 9);
        case (pick)
            4, 5: begin
                base = $urandom() >> $urandom_range(0, 31);
            end
            6, 7: begin
                base = $urandom_range(0, 65535);
                base = base * base + $urandom_range(0, 2) - 1;
            end
            8: begin
                base = $urandom_range(0, 3);
            end
            9: begin
                base = 32'hFFFF_FFFF - $urandom_range(0, 1023);
            end
            default: begin
                base = $urandom();
            end
        endcase
        return base;
    endfunction

    // Sender idle time between beats. Most gaps are short, a few are long,
    // and one stretch of operands goes back to back with no gap at all.
    function automatic int unsigned sender_gap(input int unsigned index);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (index >= 400 && index < 600) return 0;
        if (roll < 60) return 0;
        if (roll < 96) return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    // Offers one operand beat and holds it until the block takes it. The
    // gap that follows is entered at the accepting edge, so that valid gets
    // a single assignment per edge: either it stays high for the next beat,
    // or it drops here.
    task automatic send_operand(input logic [VAL_W-1:0] operand, input int unsigned index);
        int unsigned gap;
        i_valid <= 1'b1;
        i_value <= operand;
        do @(posedge i_clk); while (!o_ready);
        gap = sender_gap(index);
        if (gap != 0) begin
            i_valid <= 1'b0;
            i_value <= $urandom();
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Receiver. It counts the root beats it takes and, twice in the run,
    // refuses results for a long stretch while the sender keeps offering, so
    // that the output register and the emit step both fill and the block
    // stops taking operands. Otherwise it stalls at random, with one stretch
    // of beats where it never stalls.
    initial begin
        int unsigned root_beats;
        int unsigned ready_low_left;
        int unsigned hold_stage;
        int unsigned roll;
        root_beats     = 0;
        ready_low_left = 0;
        hold_stage     = 0;
        i_ready        = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) root_beats++;
            roll = $urandom_range(0, 99);
            if (ready_low_left != 0) begin
                ready_low_left--;
                i_ready <= 1'b0;
            end else if ((hold_stage == 0 && root_beats >= 150) ||
                         (hold_stage == 1 && root_beats >= 1200)) begin
                hold_stage++;
                ready_low_left = HOLD_CYCLES - 1;
                i_ready <= 1'b0;
            end else if ((root_beats >= 700 && root_beats < 900) || roll < 70) begin
                i_ready <= 1'b1;
            end else begin
                ready_low_left = (roll < 96) ? $urandom_range(0, 3) : $urandom_range(20, 80);
                i_ready <= 1'b0;
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_value = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_OPS[k]) send_operand(DIRECTED_OPS[k], k);
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            send_operand(random_operand(), k);
        end
        i_valid <= 1'b0;

        // The checker's pending count is a register that takes in the last operand
        // at its beat. Every root must come back; then give the block time to show
        // any stray beat before the verdict.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
